[hw/rtl/euxq_pkg.sv]
// Shared constants, types and the arctangent table for the Euler-to-quaternion pipeline.
package euxq_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int FRACTION_BITS = 14;
	localparam int CORDIC_STEPS  = 30;
	localparam int CW            = 33;
	localparam int QW            = 32;
	localparam int SQRT_STEPS    = 32;
	localparam int QUOT_BITS     = FRACTION_BITS + 1;
	localparam int DIV_W         = QW + FRACTION_BITS + 2;
	localparam int QPROD_STAGES  = 6;
	localparam int LAT_PIPE      = (CORDIC_STEPS + 1) + QPROD_STAGES + SQRT_STEPS + (QUOT_BITS + 1);

	localparam logic signed [CW-1:0] CORDIC_START = 33'sd652032874;

	typedef logic signed [QW-1:0] comp_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		comp_t w;
	} quat_t;

	// Arctangent of 2^-i in units where a full turn is 2^32.
	function automatic logic signed [CW-1:0] atan_step(input int i);
		logic signed [CW-1:0] v;
		case (i)
			0:  v = 33'sd536870912;
			1:  v = 33'sd316933406;
			2:  v = 33'sd167458907;
			3:  v = 33'sd85004756;
			4:  v = 33'sd42667331;
			5:  v = 33'sd21354465;
			6:  v = 33'sd10679838;
			7:  v = 33'sd5340245;
			8:  v = 33'sd2670163;
			9:  v = 33'sd1335087;
			10: v = 33'sd667544;
			11: v = 33'sd333772;
			12: v = 33'sd166886;
			13: v = 33'sd83443;
			14: v = 33'sd41722;
			15: v = 33'sd20861;
			16: v = 33'sd10430;
			17: v = 33'sd5215;
			18: v = 33'sd2608;
			19: v = 33'sd1304;
			20: v = 33'sd652;
			21: v = 33'sd326;
			22: v = 33'sd163;
			23: v = 33'sd81;
			24: v = 33'sd41;
			25: v = 33'sd20;
			26: v = 33'sd10;
			27: v = 33'sd5;
			28: v = 33'sd3;
			29: v = 33'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/euxq_cordic.sv]
// Pipelined CORDIC that gives the cosine and sine of a half binary angle in Q1.30.
module euxq_cordic (
	input  logic                              clk,
	input  logic                              en,
	input  logic [euxq_pkg::ANGLE_BITS-1:0]   angle,
	output euxq_pkg::comp_t                   cos_val,
	output euxq_pkg::comp_t                   sin_val
);

	localparam int N  = euxq_pkg::CORDIC_STEPS;
	localparam int CW = euxq_pkg::CW;
	localparam int QW = euxq_pkg::QW;
	localparam int AB = euxq_pkg::ANGLE_BITS;

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [CW-1:0] z_s [0:N];
	logic                 up_s [0:N];
	logic signed [CW-1:0] neg_y;

	// Entry stage folds the upper quarter of the half angle, then one rotation per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= euxq_pkg::CORDIC_START;
			y_s[0]  <= '0;
			z_s[0]  <= {{(CW-31+1){1'b0}}, angle[AB-2:0], {(31-AB){1'b0}}};
			up_s[0] <= angle[AB-1];
			for (int k = 0; k < N; k++) begin
				up_s[k+1] <= up_s[k];
				if (!z_s[k][CW-1]) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - euxq_pkg::atan_step(k);
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + euxq_pkg::atan_step(k);
				end
			end
		end
	end

	// Undo the quarter-turn fold.
	assign neg_y   = -y_s[N];
	assign cos_val = up_s[N] ? neg_y[QW-1:0] : x_s[N][QW-1:0];
	assign sin_val = up_s[N] ? x_s[N][QW-1:0] : y_s[N][QW-1:0];

endmodule

[hw/rtl/euxq_qprod.sv]
// Quaternion product of the three axis rotations and its squared length.
module euxq_qprod (
	input  logic              clk,
	input  logic              en,
	input  euxq_pkg::comp_t   cx,
	input  euxq_pkg::comp_t   sx,
	input  euxq_pkg::comp_t   cy,
	input  euxq_pkg::comp_t   sy,
	input  euxq_pkg::comp_t   cz,
	input  euxq_pkg::comp_t   sz,
	output euxq_pkg::quat_t   prod,
	output logic [63:0]       norm_sq
);

	localparam logic signed [63:0] HALF = 64'sd536870912;

	logic signed [63:0] a_s1 [0:3];
	euxq_pkg::comp_t    cx_s1, sx_s1, cx_s2, sx_s2;
	euxq_pkg::quat_t    t_s2;
	logic signed [63:0] b_s3 [0:7];
	euxq_pkg::quat_t    p_s4, p_s5, p_s6;
	logic signed [63:0] sq_s5 [0:3];
	logic [63:0]        n2_s6;
	logic signed [63:0] rx, ry, rz, rw, ux, uy, uz, uw;

	// Rounding of the z*y product terms.
	assign rx = (-a_s1[0] + HALF) >>> 30;
	assign ry = (a_s1[1] + HALF) >>> 30;
	assign rz = (a_s1[2] + HALF) >>> 30;
	assign rw = (a_s1[3] + HALF) >>> 30;

	// Sums of the second product, rounded to Q1.30.
	assign ux = (b_s3[0] + b_s3[1] + HALF) >>> 30;
	assign uy = (b_s3[2] + b_s3[3] + HALF) >>> 30;
	assign uz = (b_s3[4] - b_s3[5] + HALF) >>> 30;
	assign uw = (b_s3[6] - b_s3[7] + HALF) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: qz*qy has a single product per component.
			a_s1[0] <= sz * sy;
			a_s1[1] <= cz * sy;
			a_s1[2] <= sz * cy;
			a_s1[3] <= cz * cy;
			cx_s1   <= cx;
			sx_s1   <= sx;
			// Stage 2: round.
			t_s2.x  <= rx[31:0];
			t_s2.y  <= ry[31:0];
			t_s2.z  <= rz[31:0];
			t_s2.w  <= rw[31:0];
			cx_s2   <= cx_s1;
			sx_s2   <= sx_s1;
			// Stage 3: products with qx.
			b_s3[0] <= t_s2.w * sx_s2;
			b_s3[1] <= t_s2.x * cx_s2;
			b_s3[2] <= t_s2.y * cx_s2;
			b_s3[3] <= t_s2.z * sx_s2;
			b_s3[4] <= t_s2.z * cx_s2;
			b_s3[5] <= t_s2.y * sx_s2;
			b_s3[6] <= t_s2.w * cx_s2;
			b_s3[7] <= t_s2.x * sx_s2;
			// Stage 4: sum and round.
			p_s4.x  <= ux[31:0];
			p_s4.y  <= uy[31:0];
			p_s4.z  <= uz[31:0];
			p_s4.w  <= uw[31:0];
			// Stage 5: squares.
			sq_s5[0] <= p_s4.x * p_s4.x;
			sq_s5[1] <= p_s4.y * p_s4.y;
			sq_s5[2] <= p_s4.z * p_s4.z;
			sq_s5[3] <= p_s4.w * p_s4.w;
			p_s5     <= p_s4;
			// Stage 6: squared length.
			n2_s6    <= 64'(sq_s5[0]) + 64'(sq_s5[1]) + 64'(sq_s5[2]) + 64'(sq_s5[3]);
			p_s6     <= p_s5;
		end
	end

	assign prod    = p_s6;
	assign norm_sq = n2_s6;

endmodule

[hw/rtl/euxq_isqrt.sv]
// Pipelined integer square root, two radicand bits per stage; carries the quaternion along.
module euxq_isqrt (
	input  logic                  clk,
	input  logic                  en,
	input  logic [63:0]           norm_sq,
	input  euxq_pkg::quat_t       prod_in,
	output logic [31:0]           len,
	output euxq_pkg::quat_t       prod_out
);

	localparam int N = euxq_pkg::SQRT_STEPS;

	logic [63:0]     n_s [0:N-1];
	logic [63:0]     r_s [0:N-1];
	euxq_pkg::quat_t p_s [0:N-1];
	logic [63:0]     n_c [0:N-1];
	logic [63:0]     r_c [0:N-1];
	euxq_pkg::quat_t p_c [0:N-1];

	// Stage inputs: the first stage reads the ports.
	always_comb begin
		n_c[0] = norm_sq;
		r_c[0] = '0;
		p_c[0] = prod_in;
		for (int k = 1; k < N; k++) begin
			n_c[k] = n_s[k-1];
			r_c[k] = r_s[k-1];
			p_c[k] = p_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				p_s[k] <= p_c[k];
				if (n_c[k] >= r_c[k] + (64'd1 << (62 - 2*k))) begin
					n_s[k] <= n_c[k] - (r_c[k] + (64'd1 << (62 - 2*k)));
					r_s[k] <= (r_c[k] >> 1) + (64'd1 << (62 - 2*k));
				end else begin
					n_s[k] <= n_c[k];
					r_s[k] <= r_c[k] >> 1;
				end
			end
		end
	end

	assign len      = r_s[N-1][31:0];
	assign prod_out = p_s[N-1];

endmodule

[hw/rtl/euxq_div.sv]
// Four-lane restoring divider, one quotient bit per stage, that scales each component by 1/len.
module euxq_div (
	input  logic                                clk,
	input  logic                                en,
	input  euxq_pkg::quat_t                     prod,
	input  logic [31:0]                         len,
	output logic [euxq_pkg::QUOT_BITS-1:0]      quo [0:3],
	output logic [3:0]                          neg,
	output logic                                len_zero
);

	localparam int N  = euxq_pkg::QUOT_BITS;
	localparam int DW = euxq_pkg::DIV_W;
	localparam int FB = euxq_pkg::FRACTION_BITS;

	logic [DW-1:0]  rem_s [0:N][0:3];
	logic [N-1:0]   q_s   [0:N][0:3];
	logic [31:0]    den_s [0:N];
	logic [3:0]     neg_s [0:N];
	logic           zero_s [0:N];
	euxq_pkg::comp_t comp [0:3];
	logic [31:0]    mag  [0:3];

	assign comp[0] = prod.x;
	assign comp[1] = prod.y;
	assign comp[2] = prod.z;
	assign comp[3] = prod.w;

	// Magnitudes of the components.
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			mag[l] = comp[l][31] ? 32'(-comp[l]) : 32'(comp[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Entry stage: scaled numerator plus half the divisor for rounding.
			den_s[0]  <= len;
			zero_s[0] <= (len == '0);
			for (int l = 0; l < 4; l++) begin
				rem_s[0][l] <= {{(DW-32-FB){1'b0}}, mag[l], {FB{1'b0}}} + DW'(len >> 1);
				q_s[0][l]   <= '0;
				neg_s[0][l] <= comp[l][31];
			end
			// One quotient bit per stage, most significant first.
			for (int k = 0; k < N; k++) begin
				den_s[k+1]  <= den_s[k];
				zero_s[k+1] <= zero_s[k];
				neg_s[k+1]  <= neg_s[k];
				for (int l = 0; l < 4; l++) begin
					if (rem_s[k][l] >= (DW'(den_s[k]) << (N - 1 - k))) begin
						rem_s[k+1][l] <= rem_s[k][l] - (DW'(den_s[k]) << (N - 1 - k));
						q_s[k+1][l]   <= {q_s[k][l][N-2:0], 1'b1};
					end else begin
						rem_s[k+1][l] <= rem_s[k][l];
						q_s[k+1][l]   <= {q_s[k][l][N-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign quo[0]   = q_s[N][0];
	assign quo[1]   = q_s[N][1];
	assign quo[2]   = q_s[N][2];
	assign quo[3]   = q_s[N][3];
	assign neg      = neg_s[N];
	assign len_zero = zero_s[N];

endmodule

[hw/rtl/euler_xyz_to_canonical_quaternion.sv]
// Top level: Euler XYZ angles to a canonical unit quaternion in signed Q1.14.
//
// Input channel s_*: one transaction carries angle_x, angle_y and angle_z as
// binary angles (a full turn is 65536). Output channel m_*: one transaction
// carries quat_x, quat_y, quat_z (signed Q1.14) and quat_w (unsigned Q1.14).
// Every input transaction gives exactly one output transaction, in order.
//
// The block takes one transaction per clock cycle while the output is not
// stalled. From acceptance to m_tvalid a transaction passes through the CORDIC
// stages, the quaternion product and squared length, the square root (two
// radicand bits per stage), the divider (one quotient bit per stage) and one
// output register.
//
// The whole pipeline advances together whenever the output register is empty
// or being read, so s_tready is high while m_tvalid is low or m_tready is high.
// When the receiver stalls, every stage holds and nothing is lost or repeated.
// Reset empties the pipeline; no result is offered until new items arrive.
module euler_xyz_to_canonical_quaternion (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // angle_x[15:0], angle_y[31:16], angle_z[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[62:48]
);

	localparam int L  = euxq_pkg::LAT_PIPE;
	localparam int QB = euxq_pkg::QUOT_BITS;
	localparam int FB = euxq_pkg::FRACTION_BITS;

	logic                en;
	logic [L-1:0]        vld_q;
	logic                out_vld_q;
	logic [63:0]         out_data_q;
	euxq_pkg::comp_t     cx, sx, cy, sy, cz, sz;
	euxq_pkg::quat_t     prod_a, prod_b;
	logic [63:0]         norm_sq;
	logic [31:0]         len;
	logic [QB-1:0]       quo [0:3];
	logic [3:0]          neg;
	logic                len_zero;
	logic [FB:0]         sat [0:3];
	logic signed [15:0]  sval [0:3];
	logic signed [15:0]  res [0:3];
	logic [FB:0]         w_mag;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	euxq_cordic u_cordic_x (.clk(clk), .en(en), .angle(s_tdata[15:0]),  .cos_val(cx), .sin_val(sx));
	euxq_cordic u_cordic_y (.clk(clk), .en(en), .angle(s_tdata[31:16]), .cos_val(cy), .sin_val(sy));
	euxq_cordic u_cordic_z (.clk(clk), .en(en), .angle(s_tdata[47:32]), .cos_val(cz), .sin_val(sz));

	euxq_qprod u_qprod (
		.clk(clk), .en(en),
		.cx(cx), .sx(sx), .cy(cy), .sy(sy), .cz(cz), .sz(sz),
		.prod(prod_a), .norm_sq(norm_sq)
	);

	euxq_isqrt u_isqrt (
		.clk(clk), .en(en), .norm_sq(norm_sq), .prod_in(prod_a),
		.len(len), .prod_out(prod_b)
	);

	euxq_div u_div (
		.clk(clk), .en(en), .prod(prod_b), .len(len),
		.quo(quo), .neg(neg), .len_zero(len_zero)
	);

	// Saturate, restore signs, then flip into the w >= 0 hemisphere; a zero length gives the identity.
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			sat[l]  = (quo[l] > QB'(1 << FB)) ? (FB+1)'(1 << FB) : quo[l][FB:0];
			sval[l] = neg[l] ? -16'(sat[l]) : 16'(sat[l]);
		end
		if (len_zero) begin
			res[0] = '0;
			res[1] = '0;
			res[2] = '0;
			res[3] = 16'(1 << FB);
		end else if (sval[3] < 0) begin
			for (int l = 0; l < 4; l++) begin
				res[l] = -sval[l];
			end
		end else begin
			for (int l = 0; l < 4; l++) begin
				res[l] = sval[l];
			end
		end
		w_mag = res[3][FB:0];
	end

	// Valid bits that travel with the pipeline, and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[L-2:0], s_tvalid};
			out_vld_q <= vld_q[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {1'b0, w_mag, res[2], res[1], res[0]};
		end
	end

endmodule
